// ===== rtl/bm3_pkg.sv =====
// Shared types, register codes and constants for the 3x3 binary morphology block.
`timescale 1ns / 1ps
`default_nettype none

package bm3_pkg;

    // Field and register widths
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int MODE_W      = 3;
    localparam int MASK_W      = 9;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 16;
    localparam int PIX_W       = 8;
    localparam int FLAG_W      = 2;
    localparam int ROW_ENTRY_W = 2 * FLAG_W;
    localparam int WIN_W       = 9 * FLAG_W;

    // Output queue depth and its pointer width
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PW    = 2;

    // Pixel levels
    localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

    // Flag bits kept per pixel
    localparam int FLAG_BG_BIT = 0;
    localparam int FLAG_FG_BIT = 1;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_OP_MODE      = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HIT_MASK     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MISS_MASK    = 3'd4;

    // Register reset values
    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 16'd480;
    localparam logic [MODE_W-1:0] RST_OP_MODE      = 3'd0;
    localparam logic [MASK_W-1:0] RST_HIT_MASK     = 9'd186;
    localparam logic [MASK_W-1:0] RST_MISS_MASK    = 9'd0;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ERODE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIT_MISS    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INNER_EDGE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUTER_EDGE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BOTH_EDGE   = 3'd5;

    // Input kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Control carried from the position stage to the window stage
    typedef struct packed {
        logic              emit;
        logic              frame_end;
        logic [MASK_W-1:0] pts_ok;
        logic [FLAG_W-1:0] newf;
        logic              fwd;
    } t_s1_ctrl;

    // One result word
    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] pixel;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/binary_morphology_3x3.sv =====
// A result word passes the window stage register and then the result queue.
// Results trail the pixels by frame_width+1 words; drain words flush the last ones.
// Throughput: one word per cycle while the result queue has room; the row store takes
// one read and one write a cycle. A 3-entry result queue absorbs master-side stalls.
// Reset (i_rst_n low, synchronous): clears positions, window and queue, loads the
// register defaults; the row store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module binary_morphology_3x3 import bm3_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    // input words
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [PIX_W-1:0]  s_axis_tdata,  // [7:0] pixel_value
    input  wire logic [0:0]        s_axis_tuser,  // [0] operation
    // result words
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,  // [7:0] pixel_out
    output logic                   m_axis_tlast   // frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > FW_W) ? CW : FW_W;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

    // Configuration registers
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [MODE_W-1:0] r_op_mode;
    logic [MASK_W-1:0] r_hit_mask;
    logic [MASK_W-1:0] r_miss_mask;

    // Stream positions
    logic [AW-1:0]   r_in_col;
    logic [FH_W-1:0] r_in_row;
    logic [AW-1:0]   r_out_col;
    logic [FH_W-1:0] r_out_row;

    // Window stage inputs
    logic          r_s1_valid;
    t_s1_ctrl      r_s1_ctrl;
    logic [AW-1:0] r_s1_col;

    logic [WW-1:0]   w_eff;
    logic [FH_W-1:0] h_eff;
    logic            acc;
    logic            live;
    logic            draining;
    logic            emit;
    logic [WW:0]     in_col_p1;
    logic            in_wrap;
    logic [WW:0]     out_col_p1;
    logic [FH_W:0]   out_row_p1;
    logic            ok_left;
    logic            ok_right;
    logic            ok_up;
    logic            ok_down;
    logic            fe;
    t_s1_ctrl        ctrl;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ROW_ENTRY_W-1:0] ram_wdata;
    logic [ROW_ENTRY_W-1:0] ram_rdata;
    logic                   push;
    t_out_word              push_word;
    t_out_word              out_word;
    logic [OUT_PW-1:0]      q_count;
    logic [OUT_PW:0]        q_pending;

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_op_mode      <= RST_OP_MODE;
            r_hit_mask     <= RST_HIT_MASK;
            r_miss_mask    <= RST_MISS_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                CFG_OP_MODE:      r_op_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_HIT_MASK:     r_hit_mask     <= i_cfg_data[MASK_W-1:0];
                CFG_MISS_MASK:    r_miss_mask    <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_frame_width) > MAXW) begin
            w_eff = MAXW;
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    // Accept while the queue has room for everything in flight
    assign q_pending     = {1'b0, q_count} + (OUT_PW+1)'(r_s1_valid && r_s1_ctrl.emit);
    assign s_axis_tready = (q_pending < (OUT_PW+1)'(OUT_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Drop drain words that arrive before the frame is complete
    assign draining = (r_in_row >= h_eff);
    assign live     = acc && (draining || (s_axis_tuser[0] != OP_DRAIN));

    // Positions and boundary tests
    assign emit       = (r_in_row >= FH_W'(2)) || (r_in_row == FH_W'(1) && r_in_col != '0);
    assign in_col_p1  = (WW+1)'(r_in_col) + 1'b1;
    assign in_wrap    = (in_col_p1 >= {1'b0, w_eff});
    assign out_col_p1 = (WW+1)'(r_out_col) + 1'b1;
    assign out_row_p1 = {1'b0, r_out_row} + 1'b1;
    assign ok_left    = (r_out_col != '0);
    assign ok_right   = (out_col_p1 < {1'b0, w_eff});
    assign ok_up      = (r_out_row != '0);
    assign ok_down    = (out_row_p1 < {1'b0, h_eff});
    assign fe         = !ok_right && !ok_down;

    always_comb begin
        ctrl.emit      = emit;
        ctrl.frame_end = fe;
        for (int k = 0; k < MASK_W; k++) begin
            ctrl.pts_ok[k] = !((k % 3 == 0) && !ok_left)  &&
                             !((k % 3 == 2) && !ok_right) &&
                             !((k / 3 == 0) && !ok_up)    &&
                             !((k / 3 == 2) && !ok_down);
        end
        if (draining) begin
            ctrl.newf = '0;
        end else begin
            ctrl.newf[FLAG_BG_BIT] = (s_axis_tdata == PIX_BG);
            ctrl.newf[FLAG_FG_BIT] = (s_axis_tdata == PIX_FG);
        end
        ctrl.fwd = r_s1_valid && (r_s1_col == r_in_col);
    end

    // Advance positions; restart at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (live) begin
            if (emit && fe) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_wrap) begin
                    r_in_col <= '0;
                    if (r_in_row != '1) begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= in_col_p1[AW-1:0];
                end
                if (emit) begin
                    if (!ok_right) begin
                        r_out_col <= '0;
                        if (r_out_row != '1) begin
                            r_out_row <= r_out_row + 1'b1;
                        end
                    end else begin
                        r_out_col <= out_col_p1[AW-1:0];
                    end
                end
            end
        end
    end

    // Hand the word to the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (live) begin
            r_s1_ctrl <= ctrl;
            r_s1_col  <= r_in_col;
        end
    end

    // Row store: {two rows up, one row up} flags per column
    bm3_ram #(
        .WIDTH (ROW_ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (live),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    bm3_window #(
        .AW (AW)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_ctrl      (r_s1_ctrl),
        .i_col       (r_s1_col),
        .i_rdata     (ram_rdata),
        .i_op_mode   (r_op_mode),
        .i_hit_mask  (r_hit_mask),
        .i_miss_mask (r_miss_mask),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_push      (push),
        .o_push_word (push_word)
    );

    bm3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_word  (out_word),
        .o_count (q_count)
    );

    assign m_axis_tdata = out_word.pixel;
    assign m_axis_tlast = out_word.frame_end;

endmodule

`default_nettype wire

// ===== rtl/bm3_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bm3_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read; a read of the address written in the same cycle sees old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bm3_window.sv =====
// Window stage: row store write-back, 3x3 window shift and morphology result.
`timescale 1ns / 1ps
`default_nettype none

module bm3_window import bm3_pkg::*; #(
    parameter int AW = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire t_s1_ctrl               i_ctrl,
    input  wire logic [AW-1:0]          i_col,
    input  wire logic [ROW_ENTRY_W-1:0] i_rdata,
    input  wire logic [MODE_W-1:0]      i_op_mode,
    input  wire logic [MASK_W-1:0]      i_hit_mask,
    input  wire logic [MASK_W-1:0]      i_miss_mask,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [ROW_ENTRY_W-1:0]      o_wdata,
    output logic                        o_push,
    output t_out_word                   o_push_word
);

    logic [WIN_W-1:0]       r_win;
    logic [ROW_ENTRY_W-1:0] r_last_wdata;

    logic [ROW_ENTRY_W-1:0] src;
    logic [FLAG_W-1:0]      top_f;
    logic [FLAG_W-1:0]      mid_f;
    logic [WIN_W-1:0]       nw;
    logic [2:0][FLAG_W-1:0] incoming;
    logic [MASK_W-1:0]      f_bg;
    logic [MASK_W-1:0]      f_fg;
    logic                   erode_ok;
    logic                   dilate_ok;
    logic                   miss_ok;
    logic                   res;

    // Take the entry just written when the read raced the write
    assign src   = i_ctrl.fwd ? r_last_wdata : i_rdata;
    assign top_f = src[2*FLAG_W-1:FLAG_W];
    assign mid_f = src[FLAG_W-1:0];

    // Age the row stores: middle row moves to top, new pixel becomes middle
    assign o_we    = i_valid;
    assign o_waddr = i_col;
    assign o_wdata = {mid_f, i_ctrl.newf};

    // Shift the window left, new column enters on the right
    always_comb begin
        incoming[0] = top_f;
        incoming[1] = mid_f;
        incoming[2] = i_ctrl.newf;
        for (int r = 0; r < 3; r++) begin
            nw[(r*3)*FLAG_W   +: FLAG_W] = r_win[(r*3+1)*FLAG_W +: FLAG_W];
            nw[(r*3+1)*FLAG_W +: FLAG_W] = r_win[(r*3+2)*FLAG_W +: FLAG_W];
            nw[(r*3+2)*FLAG_W +: FLAG_W] = incoming[r];
        end
    end

    // Point tests over the window
    always_comb begin
        for (int k = 0; k < MASK_W; k++) begin
            f_bg[k] = nw[k*FLAG_W + FLAG_BG_BIT];
            f_fg[k] = nw[k*FLAG_W + FLAG_FG_BIT];
        end
        erode_ok  = &(~i_hit_mask | (i_ctrl.pts_ok & ~f_bg));
        dilate_ok = |(i_hit_mask & i_ctrl.pts_ok & f_fg);
        miss_ok   = &(~i_miss_mask | (i_ctrl.pts_ok & ~f_fg));
    end

    // Select by mode
    always_comb begin
        case (i_op_mode)
            MODE_ERODE:      res = erode_ok;
            MODE_DILATE:     res = dilate_ok;
            MODE_HIT_MISS:   res = erode_ok && miss_ok;
            MODE_INNER_EDGE: res = f_fg[4] && !erode_ok;
            MODE_OUTER_EDGE: res = dilate_ok && f_bg[4];
            MODE_BOTH_EDGE:  res = dilate_ok && !erode_ok;
            default:         res = 1'b0;
        endcase
    end

    assign o_push                = i_valid && i_ctrl.emit;
    assign o_push_word.frame_end = i_ctrl.frame_end;
    assign o_push_word.pixel     = res ? PIX_FG : PIX_BG;

    // Hold the window; clear it at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_valid) begin
            r_win <= (i_ctrl.emit && i_ctrl.frame_end) ? '0 : nw;
        end
    end

    // Keep the last written entry for forwarding
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_last_wdata <= o_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bm3_out_fifo.sv =====
// Small result queue that decouples the window stage from the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module bm3_out_fifo import bm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_out_word   i_word,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_out_word        o_word,
    output logic [OUT_PW-1:0] o_count
);

    t_out_word         r_mem [OUT_DEPTH];
    logic [OUT_PW-1:0] r_wr;
    logic [OUT_PW-1:0] r_rd;
    logic [OUT_PW-1:0] r_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == OUT_PW'(OUT_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == OUT_PW'(OUT_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bm3_checker.sv =====
// Port-level checks for the 3x3 binary morphology block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module bm3_checker import bm3_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [PIX_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tlast
);

    // Results are pure black or white
    a_binary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == PIX_FG || m_axis_tdata == PIX_BG))
        else $error("result word is neither 0 nor 255");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

    // The queue starts empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // A result appears only after an accepted word has passed the window stage register and the result queue
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result word without a word accepted two cycles earlier");

    // Input backpressure only while results wait
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (.*);

`default_nettype wire
